[rtl/lct_pkg.sv]
package lct_pkg;

    // Table and tree sizes
    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int NODE_AW    = 11;
    localparam int NODE_DEPTH = 2048;

    // Reset contents of a tree node
    localparam logic signed [63:0] INIT_INTERCEPT = 64'sd1000000000000000000;
    localparam logic signed [63:0] BEST_START     = 64'sh7FFFFFFFFFFFFFFF;

    // Request codes
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // One stored line y = slope * x + icpt
    typedef struct packed {
        logic signed [31:0] slope;
        logic signed [63:0] icpt;
    } line_t;

    // Outcome of one level's compare
    typedef struct packed {
        logic               left_ok;
        logic               mid_ok;
        logic signed [63:0] q_value;
    } cmp_t;

endpackage

[rtl/lct_eval.sv]
module lct_eval (
    input  logic               clk,
    input  logic               mul_en,
    input  lct_pkg::line_t     new_line,
    input  lct_pkg::line_t     node_line,
    input  logic signed [31:0] xl,
    input  logic signed [31:0] xm,
    output lct_pkg::cmp_t      cmp
);

    logic signed [63:0] p_new_l_reg;
    logic signed [63:0] p_new_m_reg;
    logic signed [63:0] p_old_l_reg;
    logic signed [63:0] p_old_m_reg;
    logic signed [63:0] v_new_l;
    logic signed [63:0] v_new_m;
    logic signed [63:0] v_old_l;
    logic signed [63:0] v_old_m;

    // Register the four slope products of this level
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            p_new_l_reg <= 64'(new_line.slope) * 64'(xl);
            p_new_m_reg <= 64'(new_line.slope) * 64'(xm);
            p_old_l_reg <= 64'(node_line.slope) * 64'(xl);
            p_old_m_reg <= 64'(node_line.slope) * 64'(xm);
        end
    end

    // Add intercepts with 64-bit wrap and compare signed
    always_comb
    begin
        v_new_l     = p_new_l_reg + new_line.icpt;
        v_new_m     = p_new_m_reg + new_line.icpt;
        v_old_l     = p_old_l_reg + node_line.icpt;
        v_old_m     = p_old_m_reg + node_line.icpt;
        cmp.left_ok = (v_new_l <= v_old_l);
        cmp.mid_ok  = (v_new_m <= v_old_m);
        cmp.q_value = v_old_l;
    end

endmodule

[rtl/li_chao_min_line_tree.sv]
// Channel   Ports                                             Handshake
// request   req_type point_index coordinate line_slope        start & !busy
//           line_intercept
// result    min_value                                         done, one cycle
// config    cfg_data (point_count)                            cfg_valid & cfg_ready
//
// A load writes the coordinate table on acceptance and leaves busy low. An insert
// or a query walks one tree level per pass through the read, multiply and compare
// states (node memory read, multiply, add and compare), visiting up to
// ceil(log2(span)) + 1 levels, where span is the point count clamped to 1 .. 1024;
// paths that end on a shallower leaf are shorter.
// After reset a clearing pass writes all 2048 tree nodes, one per cycle, with
// busy high; configuration writes are taken throughout.
// The result receiver cannot stall: done is high for a single cycle; min_value holds until the next query result.
module li_chao_min_line_tree (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic [9:0]         point_index,
    input  logic signed [31:0] coordinate,
    input  logic signed [31:0] line_slope,
    input  logic signed [63:0] line_intercept,
    output logic               done,
    output logic signed [63:0] min_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [10:0]        cfg_data
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;

    // Memories
    lct_pkg::line_t     node_mem [lct_pkg::NODE_DEPTH];
    logic signed [31:0] coord_mem [lct_pkg::MAX_POINTS];

    // Control state
    logic [2:0]                     state_reg, state_next;
    logic [lct_pkg::NODE_AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [lct_pkg::CNT_W-1:0]      point_count_reg, point_count_next;
    logic                           done_reg, done_next;

    // Walk state and payload
    logic [lct_pkg::NODE_AW-1:0]    id_reg, id_next;
    logic [lct_pkg::IDX_W-1:0]      lo_reg, lo_next;
    logic [lct_pkg::IDX_W-1:0]      hi_reg, hi_next;
    logic [lct_pkg::IDX_W-1:0]      qidx_reg, qidx_next;
    logic                           is_query_reg, is_query_next;
    lct_pkg::line_t                 line_reg, line_next;
    logic signed [63:0]             best_reg, best_next;
    logic signed [63:0]             min_value_reg, min_value_next;

    // Memory read data
    lct_pkg::line_t                 node_rd_reg;
    logic signed [31:0]             xa_rd_reg;
    logic signed [31:0]             xb_rd_reg;

    logic                           accept;
    logic [lct_pkg::CNT_W-1:0]      span;
    logic [lct_pkg::CNT_W-1:0]      span_m1;
    logic [lct_pkg::CNT_W-1:0]      mid_sum;
    logic [lct_pkg::IDX_W-1:0]      mid;
    logic [lct_pkg::IDX_W-1:0]      xa_addr;
    logic                           node_we;
    logic [lct_pkg::NODE_AW-1:0]    node_waddr;
    lct_pkg::line_t                 node_wdata;
    lct_pkg::line_t                 clear_line;
    lct_pkg::cmp_t                  cmp;
    logic                           q_better;
    logic signed [63:0]             q_best;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign min_value = min_value_reg;

    // Clamp the point count into 1 .. MAX_POINTS
    always_comb
    begin
        if (point_count_reg == '0)
            span = lct_pkg::CNT_W'(1);
        else if (point_count_reg > lct_pkg::CNT_W'(lct_pkg::MAX_POINTS))
            span = lct_pkg::CNT_W'(lct_pkg::MAX_POINTS);
        else
            span = point_count_reg;
        span_m1 = span - lct_pkg::CNT_W'(1);
    end

    // Midpoint of the current span
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = lct_pkg::IDX_W'(mid_sum >> 1);
    assign xa_addr = is_query_reg ? qidx_reg : lo_reg;

    assign clear_line.slope = '0;
    assign clear_line.icpt  = lct_pkg::INIT_INTERCEPT;

    // Level datapath
    lct_eval u_eval (
        .clk       (clk),
        .mul_en    (state_reg == ST_MUL),
        .new_line  (line_reg),
        .node_line (node_rd_reg),
        .xl        (xa_rd_reg),
        .xm        (xb_rd_reg),
        .cmp       (cmp)
    );

    assign q_better = (cmp.q_value <= best_reg);
    assign q_best   = q_better ? cmp.q_value : best_reg;

    // Node memory write: clearing pass or winner at the midpoint
    always_comb
    begin
        node_we    = 1'b0;
        node_waddr = id_reg;
        node_wdata = line_reg;
        if (state_reg == ST_CLEAR)
        begin
            node_we    = 1'b1;
            node_waddr = clr_addr_reg;
            node_wdata = clear_line;
        end
        else if (state_reg == ST_CMP && !is_query_reg && cmp.mid_ok)
        begin
            node_we = 1'b1;
        end
    end

    // Node memory
    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_waddr] <= node_wdata;
        if (state_reg == ST_READ)
            node_rd_reg <= node_mem[id_reg];
    end

    // Coordinate memory, two read ports
    always_ff @(posedge clk)
    begin
        if (accept && req_type == lct_pkg::REQ_LOAD)
            coord_mem[point_index] <= coordinate;
        if (state_reg == ST_READ)
        begin
            xa_rd_reg <= coord_mem[xa_addr];
            xb_rd_reg <= coord_mem[mid];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        point_count_next = point_count_reg;
        done_next        = 1'b0;
        id_next          = id_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        qidx_next        = qidx_reg;
        is_query_next    = is_query_reg;
        line_next        = line_reg;
        best_next        = best_reg;
        min_value_next   = min_value_reg;

        if (cfg_valid && cfg_ready)
            point_count_next = cfg_data;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + lct_pkg::NODE_AW'(1);
                if (clr_addr_reg == lct_pkg::NODE_AW'(lct_pkg::NODE_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    id_next = lct_pkg::NODE_AW'(1);
                    lo_next = '0;
                    hi_next = span_m1[lct_pkg::IDX_W-1:0];
                    case (req_type)
                        lct_pkg::REQ_INSERT:
                        begin
                            line_next.slope = line_slope;
                            line_next.icpt  = line_intercept;
                            is_query_next   = 1'b0;
                            state_next      = ST_READ;
                        end
                        lct_pkg::REQ_QUERY:
                        begin
                            if ({1'b0, point_index} > span_m1)
                                qidx_next = span_m1[lct_pkg::IDX_W-1:0];
                            else
                                qidx_next = point_index;
                            best_next     = lct_pkg::BEST_START;
                            is_query_next = 1'b1;
                            state_next    = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = ST_READ;
                if (is_query_reg)
                begin
                    best_next = q_best;
                    if (lo_reg == hi_reg)
                    begin
                        done_next      = 1'b1;
                        min_value_next = q_best;
                        state_next     = ST_IDLE;
                    end
                    else if (qidx_reg <= mid)
                    begin
                        id_next = {id_reg[lct_pkg::NODE_AW-2:0], 1'b0};
                        hi_next = mid;
                    end
                    else
                    begin
                        id_next = {id_reg[lct_pkg::NODE_AW-2:0], 1'b1};
                        lo_next = mid + lct_pkg::IDX_W'(1);
                    end
                end
                else
                begin
                    // Keep the winner here, send the loser down
                    if (cmp.mid_ok)
                        line_next = node_rd_reg;
                    if (lo_reg == hi_reg)
                        state_next = ST_IDLE;
                    else if (cmp.left_ok != cmp.mid_ok)
                    begin
                        id_next = {id_reg[lct_pkg::NODE_AW-2:0], 1'b0};
                        hi_next = mid;
                    end
                    else
                    begin
                        id_next = {id_reg[lct_pkg::NODE_AW-2:0], 1'b1};
                        lo_next = mid + lct_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            point_count_reg <= lct_pkg::CNT_W'(lct_pkg::MAX_POINTS);
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            point_count_reg <= point_count_next;
            done_reg        <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        qidx_reg      <= qidx_next;
        is_query_reg  <= is_query_next;
        line_reg      <= line_next;
        best_reg      <= best_next;
        min_value_reg <= min_value_next;
    end

endmodule

[tb/sv/li_chao_min_line_tree_tb.sv]
module li_chao_min_line_tree_tb;

    localparam logic [1:0] REQ_NONE      = 2'd3;
    localparam int         DRAIN_CYCLES  = 40;
    localparam int         LIMIT_CYCLES  = 1_000_000;
    localparam int         SEGMENTS      = 6;
    localparam int         SEG_REQUESTS  = 35;
    localparam int         FULL_SPAN_MAX = 120;
    localparam int         SPARSE_LOADS  = 12;

    // Tracks the line tree and the coordinate table, and holds the minima
    // that outstanding queries are due to return
    class min_line_board;
        lct_pkg::line_t            tree_line [lct_pkg::NODE_DEPTH];
        logic signed [31:0]        coord_at [lct_pkg::MAX_POINTS];
        logic [lct_pkg::CNT_W-1:0] point_count;
        logic signed [63:0]        pending_minima [$];
        int                        errors;
        int                        n_load;
        int                        n_insert;
        int                        n_query;

        function new();
            foreach (tree_line[i])
            begin
                tree_line[i].slope = '0;
                tree_line[i].icpt  = lct_pkg::INIT_INTERCEPT;
            end
            foreach (coord_at[i])
                coord_at[i] = '0;
            point_count = lct_pkg::CNT_W'(lct_pkg::MAX_POINTS);
            errors      = 0;
            n_load      = 0;
            n_insert    = 0;
            n_query     = 0;
        endfunction

        // Zero counts as one point, anything past the table saturates
        function int span_size();
            if (point_count == 0)
                return 1;
            if (point_count > lct_pkg::MAX_POINTS)
                return lct_pkg::MAX_POINTS;
            return point_count;
        endfunction

        // Evaluate slope * x + icpt with 64-bit wrap
        static function logic signed [63:0] line_at(lct_pkg::line_t ln,
                                                    logic signed [31:0] x);
            logic signed [63:0] s;
            logic signed [63:0] xx;
            s  = ln.slope;
            xx = x;
            return s * xx + ln.icpt;
        endfunction

        // Walk root to leaf, keeping the lower line at each midpoint
        function void add_line(lct_pkg::line_t cand);
            int             id;
            int             lo;
            int             hi;
            int             mid;
            logic           below_left;
            logic           below_mid;
            lct_pkg::line_t held;
            id = 1;
            lo = 0;
            hi = span_size() - 1;
            while (id < lct_pkg::NODE_DEPTH)
            begin
                mid        = (lo + hi) / 2;
                below_left = line_at(cand, coord_at[lo]) <= line_at(tree_line[id], coord_at[lo]);
                below_mid  = line_at(cand, coord_at[mid]) <= line_at(tree_line[id], coord_at[mid]);
                if (below_mid)
                begin
                    held          = tree_line[id];
                    tree_line[id] = cand;
                    cand          = held;
                end
                if (lo == hi)
                    break;
                if (below_left != below_mid)
                begin
                    id = 2 * id;
                    hi = mid;
                end
                else
                begin
                    id = 2 * id + 1;
                    lo = mid + 1;
                end
            end
        endfunction

        // Minimum of the stored lines on the path to the leaf of idx
        function logic signed [63:0] lowest_on_path(int idx);
            int                 id;
            int                 lo;
            int                 hi;
            int                 mid;
            logic signed [31:0] x;
            logic signed [63:0] v;
            logic signed [63:0] best;
            id   = 1;
            lo   = 0;
            hi   = span_size() - 1;
            best = lct_pkg::BEST_START;
            if (idx > hi)
                idx = hi;
            x = coord_at[idx];
            while (id < lct_pkg::NODE_DEPTH)
            begin
                mid = (lo + hi) / 2;
                v   = line_at(tree_line[id], x);
                if (v <= best)
                    best = v;
                if (lo == hi)
                    break;
                if (idx <= mid)
                begin
                    id = 2 * id;
                    hi = mid;
                end
                else
                begin
                    id = 2 * id + 1;
                    lo = mid + 1;
                end
            end
            return best;
        endfunction

        // Apply an accepted request to the tracked state
        function void take_request(logic [1:0] kind, logic [9:0] idx, logic signed [31:0] x,
                                   logic signed [31:0] s, logic signed [63:0] b);
            lct_pkg::line_t ln;
            case (kind)
                lct_pkg::REQ_LOAD:
                begin
                    coord_at[idx] = x;
                    n_load++;
                end
                lct_pkg::REQ_INSERT:
                begin
                    ln.slope = s;
                    ln.icpt  = b;
                    add_line(ln);
                    n_insert++;
                end
                lct_pkg::REQ_QUERY:
                begin
                    pending_minima.push_back(lowest_on_path(idx));
                    n_query++;
                end
                default:
                    ;
            endcase
        endfunction

        // Compare one returned minimum with the oldest outstanding query
        function void match_min_value(logic signed [63:0] got);
            logic signed [63:0] want;
            if (pending_minima.size() == 0)
            begin
                $error("min_value: no query outstanding, expected none, actual %0d", got);
                errors++;
                return;
            end
            want = pending_minima.pop_front();
            if (got !== want)
            begin
                $error("min_value mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               start          = 1'b0;
    logic               busy;
    logic [1:0]         req_type       = lct_pkg::REQ_LOAD;
    logic [9:0]         point_index    = '0;
    logic signed [31:0] coordinate     = '0;
    logic signed [31:0] line_slope     = '0;
    logic signed [63:0] line_intercept = '0;
    logic               done;
    logic signed [63:0] min_value;
    logic               cfg_valid      = 1'b0;
    logic               cfg_ready;
    logic [10:0]        cfg_data       = '0;

    min_line_board board = new();
    int            sender_idle = 19;
    int            n_settings  = 0;

    li_chao_min_line_tree DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .point_index    (point_index),
        .coordinate     (coordinate),
        .line_slope     (line_slope),
        .line_intercept (line_intercept),
        .done           (done),
        .min_value      (min_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check every returned minimum as it goes by
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.match_min_value(min_value);
    end

    // Hold a request on the ports until the block takes it
    task automatic send_request(input logic [1:0] kind, input logic [9:0] idx,
                                input logic signed [31:0] x, input logic signed [31:0] s,
                                input logic signed [63:0] b);
        while ($urandom_range(0, 99) < sender_idle)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        req_type       <= kind;
        point_index    <= idx;
        coordinate     <= x;
        line_slope     <= s;
        line_intercept <= b;
        do
            @(posedge clk);
        while (busy);
        board.take_request(kind, idx, x, s, b);
    endtask

    // Drop start and wait for every outstanding query, then let walks finish
    task automatic settle(input int extra);
        start <= 1'b0;
        @(posedge clk);
        while (board.pending_minima.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_point_count(input logic [10:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.point_count = value;
        n_settings++;
    endtask

    initial
    begin
        #(LIMIT_CYCLES * 10);
        $display("li_chao_min_line_tree_tb failed");
        $finish;
    end

    initial
    begin : stimulus
        logic signed [31:0] slope;
        logic signed [63:0] icpt;
        logic [10:0]        cfg_value;
        logic [9:0]         idx;
        longint             stride;
        longint             base;
        int                 n;
        int                 roll;
        int                 useful;
        int                 loaded_idx [$];
        bit                 sparse_span;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single point span: reset tree, saturated index, extreme lines with wrap
        write_point_count(11'd0);
        send_request(lct_pkg::REQ_LOAD, 10'd0, 32'sh8000_0000, '0, '0);
        send_request(lct_pkg::REQ_QUERY, 10'd0, '0, '0, '0);
        send_request(lct_pkg::REQ_QUERY, 10'd1023, '0, '0, '0);
        send_request(lct_pkg::REQ_INSERT, 10'd0, '0, 32'sh7FFF_FFFF, 64'sh8000_0000_0000_0000);
        send_request(lct_pkg::REQ_QUERY, 10'd0, '0, '0, '0);
        send_request(lct_pkg::REQ_INSERT, 10'd0, '0, 32'sh8000_0000, 64'sh7FFF_FFFF_FFFF_FFFF);
        send_request(lct_pkg::REQ_QUERY, 10'd0, '0, '0, '0);
        send_request(REQ_NONE, 10'h3FF, -1, -1, -1);

        // Grow the span over a tree that already holds lines
        settle(DRAIN_CYCLES);
        write_point_count(11'd5);
        send_request(lct_pkg::REQ_LOAD, 10'd0, 32'sh8000_0000, '0, '0);
        send_request(lct_pkg::REQ_LOAD, 10'd1, -7, '0, '0);
        send_request(lct_pkg::REQ_LOAD, 10'd2, 0, '0, '0);
        send_request(lct_pkg::REQ_LOAD, 10'd3, 9, '0, '0);
        send_request(lct_pkg::REQ_LOAD, 10'd4, 32'sh7FFF_FFFF, '0, '0);
        send_request(lct_pkg::REQ_INSERT, 10'd0, '0, -3, 64'sd100);
        send_request(lct_pkg::REQ_INSERT, 10'd0, '0, 32'sd2, -64'sd50);
        send_request(lct_pkg::REQ_INSERT, 10'd0, '0, 32'sd2, -64'sd50);
        send_request(lct_pkg::REQ_INSERT, 10'd0, '0, -1, 64'sh8000_0000_0000_0000);
        send_request(lct_pkg::REQ_QUERY, 10'd0, '0, '0, '0);
        send_request(lct_pkg::REQ_QUERY, 10'd2, '0, '0, '0);
        send_request(lct_pkg::REQ_QUERY, 10'd4, '0, '0, '0);
        send_request(lct_pkg::REQ_QUERY, 10'd1023, '0, '0, '0);

        // Random part: three idle profiles, each a run of point count settings
        for (int prof = 0; prof < 3; prof++)
        begin
            sender_idle = (prof == 0) ? 19 : (prof == 1) ? 55 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                if (prof == 0 && seg == 1)
                    cfg_value = 11'd1024;
                else if (prof == 1 && seg == 3)
                    cfg_value = 11'd2047;
                else if (prof == 2 && seg == 0)
                    cfg_value = 11'd1;
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 5)
                        cfg_value = 11'd0;
                    else if (roll < 9)
                        cfg_value = 11'($urandom_range(41, FULL_SPAN_MAX));
                    else if (roll < 11)
                        cfg_value = 11'($urandom_range(1025, 2047));
                    else
                        cfg_value = 11'($urandom_range(2, 40));
                end
                settle(DRAIN_CYCLES);
                write_point_count(cfg_value);
                n           = board.span_size();
                sparse_span = (n > FULL_SPAN_MAX);

                // Pick an ascending coordinate spacing over the span
                if ($urandom_range(0, 1) == 0)
                    stride = $urandom_range(1, 64);
                else
                    stride = $urandom_range(1, 32'hFFFF_FFFF / n);
                base = -64'sd2147483648
                       + longint'($urandom_range(0, 32'(64'hFFFF_FFFF - stride * n)));

                // Load the whole span, or only a handful of entries on a wide one
                loaded_idx.delete();
                if (sparse_span)
                begin
                    for (int i = 0; i < SPARSE_LOADS; i++)
                        loaded_idx.push_back($urandom_range(0, n - 2));
                    loaded_idx.push_back(n - 1);
                    loaded_idx.sort();
                end
                else
                begin
                    for (int i = 0; i < n; i++)
                        loaded_idx.push_back(i);
                end
                foreach (loaded_idx[i])
                    send_request(lct_pkg::REQ_LOAD, 10'(loaded_idx[i]),
                                 32'(base + loaded_idx[i] * stride
                                     + $urandom_range(0, 32'(stride - 1))),
                                 $urandom, {$urandom, $urandom});

                // A wide span takes only queries of loaded entries, loads and unused request codes
                useful = 0;
                while (useful < SEG_REQUESTS)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 45 && !sparse_span)
                    begin
                        roll = $urandom_range(0, 9);
                        if (roll < 6)
                        begin
                            slope = $signed($urandom) >>> $urandom_range(16, 28);
                            icpt  = $signed({$urandom, $urandom}) >>> $urandom_range(20, 40);
                        end
                        else if (roll < 9)
                        begin
                            slope = $urandom;
                            icpt  = {$urandom, $urandom};
                        end
                        else
                        begin
                            case ($urandom_range(0, 3))
                                0: slope = 32'sh8000_0000;
                                1: slope = 32'sh7FFF_FFFF;
                                2: slope = '0;
                                default: slope = -1;
                            endcase
                            case ($urandom_range(0, 3))
                                0: icpt = 64'sh8000_0000_0000_0000;
                                1: icpt = 64'sh7FFF_FFFF_FFFF_FFFF;
                                2: icpt = lct_pkg::INIT_INTERCEPT;
                                default: icpt = '0;
                            endcase
                        end
                        send_request(lct_pkg::REQ_INSERT, 10'($urandom), $urandom, slope, icpt);
                        useful++;
                    end
                    else if (roll < 88)
                    begin
                        if (sparse_span)
                            idx = 10'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
                        else if ($urandom_range(0, 99) < 85)
                            idx = 10'($urandom_range(0, n - 1));
                        else
                            idx = 10'($urandom_range(0, 1023));
                        send_request(lct_pkg::REQ_QUERY, idx, $urandom, $urandom,
                                     {$urandom, $urandom});
                        useful++;
                    end
                    else if (roll < 96)
                    begin
                        // Overwrite one entry with any value, breaking the order
                        if ($urandom_range(0, 1) == 0)
                            idx = 10'($urandom_range(0, n - 1));
                        else
                            idx = 10'($urandom_range(0, 1023));
                        send_request(lct_pkg::REQ_LOAD, idx, $urandom, $urandom,
                                     {$urandom, $urandom});
                        loaded_idx.push_back(int'(idx));
                        useful++;
                    end
                    else
                        send_request(REQ_NONE, 10'($urandom), $urandom, $urandom,
                                     {$urandom, $urandom});

                    // Now and then hold off until all queries have answered
                    if ($urandom_range(0, 49) == 0)
                        settle(0);
                end
            end
        end

        settle(DRAIN_CYCLES);
        if (board.pending_minima.size() != 0)
        begin
            $error("min_value: %0d queries never answered", board.pending_minima.size());
            board.errors++;
        end

        $display("Run covered %0d inserts, %0d queries and %0d coordinate loads",
                 board.n_insert, board.n_query, board.n_load);
        $display("across %0d point count settings, including zero and saturation",
                 n_settings);
        if (board.errors == 0)
            $display("li_chao_min_line_tree_tb passed");
        else
            $display("li_chao_min_line_tree_tb failed");
        $finish;
    end

endmodule

[files.f]
rtl/lct_pkg.sv
rtl/lct_eval.sv
rtl/li_chao_min_line_tree.sv
tb/sv/li_chao_min_line_tree_tb.sv
